/* sv/perspective_point_projector_macros.svh */
// Assertion macros for the perspective point projector.
// Used by the top level; expects a clock named clk and reset rst_n in scope.
`ifndef PERSPECTIVE_POINT_PROJECTOR_MACROS_SVH
`define PERSPECTIVE_POINT_PROJECTOR_MACROS_SVH

// same-cycle implication
`define PPP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppp assertion failed");

// next-cycle implication
`define PPP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppp assertion failed");

`endif

/* sv/ppp_pkg.sv */
// Shared types, widths and helpers for the perspective point projector.
// No dependencies.
package ppp_pkg;

    localparam int COORD_W   = 32;
    localparam int DIM_W     = 13;
    localparam int PROD_W    = 48;   // Q32.32 product floored to Q32.16
    localparam int H_W       = 50;   // homogeneous coordinate
    localparam int MAG_W     = 51;   // |x + w|, |w - y|, 2|w|
    localparam int NUM_W     = 63;   // scaled numerator magnitude
    localparam int DEN_W     = 51;
    localparam int FRAC_W    = 16;
    localparam int QBITS     = 33;   // quotient bits once overflow is excluded
    localparam int LO_W      = QBITS - FRAC_W;
    localparam int DIV_LAT   = QBITS + 1;
    localparam int PIPE_DEPTH = 4 + DIV_LAT;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

    typedef enum logic { OP_LOAD = 1'b0, OP_PROJECT = 1'b1 } op_t;
    typedef enum logic { CFG_WIDTH = 1'b0, CFG_HEIGHT = 1'b1 } cfg_idx_t;

    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic visible;
        logic err;
    } tag_t;

    localparam logic [COORD_W-1:0] SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] SAT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    function automatic logic [COORD_W-1:0] ppp_saturate(
        input logic [QBITS-1:0] q, input logic ovf, input logic neg);
        logic [QBITS-1:0] negq;
        logic [COORD_W-1:0] res;
        negq = ~q + QBITS'(1);
        if (ovf)
            res = neg ? SAT_MIN : SAT_MAX;
        else if (neg)
            res = (q > QBITS'(SAT_MIN)) ? SAT_MIN : negq[COORD_W-1:0];
        else
            res = (q > QBITS'(SAT_MAX)) ? SAT_MAX : q[COORD_W-1:0];
        return res;
    endfunction

endpackage

/* sv/ppp_divider.sv */
// Pipelined restoring divider: floor(num * 2^16 / den), one quotient bit per stage.
// Depends on ppp_pkg. Flags overflow when the quotient reaches 2^33.
module ppp_divider
    import ppp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QBITS-1:0] quo,
    output logic             ovf
);

    logic [DEN_W-1:0] rem_reg [0:QBITS];
    logic [QBITS-1:0] quo_reg [0:QBITS];
    logic [QBITS-1:0] lo_reg  [0:QBITS];
    logic [DEN_W-1:0] den_reg [0:QBITS];
    logic             ovf_reg [0:QBITS];

    // overflow when num >= den * 2^LO_W; otherwise the leading remainder is below den
    always_ff @(posedge clk)
    begin
        if (en && rst_n)
        begin
            rem_reg[0] <= DEN_W'(num >> LO_W);
            lo_reg[0]  <= {num[LO_W-1:0], {FRAC_W{1'b0}}};
            quo_reg[0] <= '0;
            den_reg[0] <= den;
            ovf_reg[0] <= ({{(DEN_W+LO_W-NUM_W){1'b0}}, num} >= {den, {LO_W{1'b0}}});
        end
    end

    for (genvar i = 1; i <= QBITS; i++)
    begin : g_step
        logic [DEN_W:0]   trial;
        logic             ge;
        logic [DEN_W-1:0] rem_next;

        always_comb
        begin
            trial    = {rem_reg[i-1], lo_reg[i-1][QBITS-1]};
            ge       = (trial >= {1'b0, den_reg[i-1]});
            rem_next = ge ? DEN_W'(trial - {1'b0, den_reg[i-1]}) : DEN_W'(trial);
        end

        always_ff @(posedge clk)
        begin
            if (en && rst_n)
            begin
                rem_reg[i] <= rem_next;
                quo_reg[i] <= {quo_reg[i-1][QBITS-2:0], ge};
                lo_reg[i]  <= {lo_reg[i-1][QBITS-2:0], 1'b0};
                den_reg[i] <= den_reg[i-1];
                ovf_reg[i] <= ovf_reg[i-1];
            end
        end
    end

    assign quo = quo_reg[QBITS];
    assign ovf = ovf_reg[QBITS];

endmodule

/* sv/perspective_point_projector.sv */
// Perspective point projector: 4x4 Q16.16 matrix times (x, y, z, 1), divide by w,
// viewport map. One request can enter every cycle unless the output stalls; the
// depth is set by the 34-stage bit-serial-per-stage dividers (one each for x and y)
// behind four arithmetic stages, then the output register. Loads write the matrix
// at acceptance, give no result, and affect every later projection. The whole
// pipeline advances when the output register is empty or taken, so in_ready follows
// out_ready within the cycle. Depends on ppp_pkg, ppp_divider and the macros header.
module perspective_point_projector
    import ppp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      op,
    input  logic [3:0]                coef_index,
    input  logic signed [COORD_W-1:0] coef_value,
    input  logic signed [COORD_W-1:0] point_x,
    input  logic signed [COORD_W-1:0] point_y,
    input  logic signed [COORD_W-1:0] point_z,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [COORD_W-1:0] screen_x,
    output logic signed [COORD_W-1:0] screen_y,
    output logic                      visible,
    output logic                      divide_error,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_index,
    input  logic [DIM_W-1:0]          cfg_data
);

`include "perspective_point_projector_macros.svh"

    logic en;
    logic in_acc;
    logic [DIM_W-1:0] width_reg, height_reg;
    logic signed [COORD_W-1:0] mat_reg [16];
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic out_valid_reg;

    assign en        = !out_valid_reg || out_ready;
    assign in_ready  = en;
    assign in_acc    = in_valid && en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 16; k++)
                mat_reg[k] <= '0;
        end
        else if (in_acc && op_t'(op) == OP_LOAD)
        begin
            mat_reg[coef_index] <= coef_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[PIPE_DEPTH-2:0], in_acc && op_t'(op) == OP_PROJECT};
            out_valid_reg <= vld_reg[PIPE_DEPTH-1];
        end
    end

    // stage 1: products, floored to Q32.16 (arithmetic shift)
    logic signed [COORD_W-1:0] pt [3];
    logic signed [2*COORD_W-1:0] prod [4][3];
    logic signed [PROD_W-1:0] pf_reg [4][3];
    logic signed [COORD_W-1:0] c3_reg [4];

    assign pt[0] = point_x;
    assign pt[1] = point_y;
    assign pt[2] = point_z;

    always_comb
    begin
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 3; c++)
                prod[r][c] = (2*COORD_W)'(mat_reg[r*4+c]) * (2*COORD_W)'(pt[c]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 4; r++)
            begin
                for (int c = 0; c < 3; c++)
                    pf_reg[r][c] <= prod[r][c][2*COORD_W-1:FRAC_W];
                c3_reg[r] <= mat_reg[r*4+3];
            end
        end
    end

    // stage 2: row sums
    logic signed [H_W-1:0] h_reg [4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 4; r++)
                h_reg[r] <= H_W'(pf_reg[r][0]) + H_W'(pf_reg[r][1])
                          + H_W'(pf_reg[r][2]) + H_W'(c3_reg[r]);
        end
    end

    // stage 3: numerators, denominator, signs
    logic signed [MAG_W-1:0] numx, numy;
    logic [MAG_W-1:0] absx_reg, absy_reg, den_reg;
    logic [H_W-1:0] absw;
    tag_t tag_reg [0:PIPE_DEPTH-3];
    tag_t tag_next;

    always_comb
    begin
        numx = MAG_W'(h_reg[0]) + MAG_W'(h_reg[3]);
        numy = MAG_W'(h_reg[3]) - MAG_W'(h_reg[1]);
        absw = h_reg[3][H_W-1] ? H_W'(-h_reg[3]) : H_W'(h_reg[3]);
        tag_next.neg_x   = numx[MAG_W-1] != h_reg[3][H_W-1];
        tag_next.neg_y   = numy[MAG_W-1] != h_reg[3][H_W-1];
        tag_next.err     = (h_reg[3] == '0);
        tag_next.visible = (h_reg[3] > 0) && (h_reg[2] > 0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            absx_reg   <= numx[MAG_W-1] ? MAG_W'(-numx) : MAG_W'(numx);
            absy_reg   <= numy[MAG_W-1] ? MAG_W'(-numy) : MAG_W'(numy);
            den_reg    <= {absw, 1'b0};
            tag_reg[0] <= tag_next;
            for (int k = 1; k <= PIPE_DEPTH-3; k++)
                tag_reg[k] <= tag_reg[k-1];
        end
    end

    // stage 4: scale by the viewport size
    logic [2*NUM_W-1:0] scx, scy;
    logic [NUM_W-1:0] nx_reg, ny_reg;
    logic [DEN_W-1:0] den4_reg;

    assign scx = (2*NUM_W)'(absx_reg) * (2*NUM_W)'(width_reg);
    assign scy = (2*NUM_W)'(absy_reg) * (2*NUM_W)'(height_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg   <= scx[NUM_W-1:0];
            ny_reg   <= scy[NUM_W-1:0];
            den4_reg <= DEN_W'(den_reg);
        end
    end

    logic [QBITS-1:0] qx, qy;
    logic ovfx, ovfy;

    ppp_divider u_div_x (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (en),
        .num  (nx_reg),
        .den  (den4_reg),
        .quo  (qx),
        .ovf  (ovfx)
    );

    ppp_divider u_div_y (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (en),
        .num  (ny_reg),
        .den  (den4_reg),
        .quo  (qy),
        .ovf  (ovfy)
    );

    // output register
    tag_t tag_last;
    logic [COORD_W-1:0] sx_reg, sy_reg;
    logic vis_reg, err_reg;

    assign tag_last = tag_reg[PIPE_DEPTH-3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_reg  <= tag_last.err ? '0 : ppp_saturate(qx, ovfx, tag_last.neg_x);
            sy_reg  <= tag_last.err ? '0 : ppp_saturate(qy, ovfy, tag_last.neg_y);
            vis_reg <= tag_last.visible;
            err_reg <= tag_last.err;
        end
    end

    assign out_valid    = out_valid_reg;
    assign screen_x     = sx_reg;
    assign screen_y     = sy_reg;
    assign visible      = vis_reg;
    assign divide_error = err_reg;

    `PPP_ASSERT_IMP(a_err_zero, out_valid && divide_error, screen_x == 0 && screen_y == 0 && !visible)
    `PPP_ASSERT_NEXT(a_load_no_item, in_valid && in_ready && op == OP_LOAD, !vld_reg[0])
    `PPP_ASSERT_NEXT(a_stall_holds, !en, $stable(vld_reg) && out_valid)

endmodule
